/* rtl/cfmt_pkg.sv */
package cfmt_pkg;

   // Table geometry
   localparam int TABLE_ENTRIES = 16;
   localparam int IDX_W         = $clog2(TABLE_ENTRIES);
   localparam int USED_W        = $clog2(TABLE_ENTRIES + 1);

   // Field widths
   localparam int STD_ID_W   = 11;
   localparam int EXT_ID_W   = 29;
   localparam int LENGTH_W   = 4;
   localparam int PAYLOAD_W  = 64;
   localparam int TIME_W     = 32;
   localparam int SLOT_W     = 4;
   localparam int COUNT_W    = 32;
   localparam int PAYLOAD_BYTES = PAYLOAD_W / 8;

   // Reset value of the payload match id register
   localparam logic [STD_ID_W-1:0] DATA_MATCH_ID_RST = 11'd1023;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MATCH,
      ST_WRITE
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic load_frame;
      logic latch_match;
      logic commit;
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic out_free;
   } status_type;

   // Mask of the first len payload bytes, all bytes for len of eight or more
   function automatic logic [PAYLOAD_W-1:0] byte_mask(input logic [LENGTH_W-1:0] len);
      logic [PAYLOAD_W-1:0] mask;
      mask = '0;
      for (int b = 0; b < PAYLOAD_BYTES; b++) begin
         if (LENGTH_W'(b) < len) begin
            mask[8*b +: 8] = 8'hff;
         end
      end
      return mask;
   endfunction

endpackage

/* rtl/cfmt_ctrl.sv */
module cfmt_ctrl
   import cfmt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_MATCH;
            end
         end
         ST_MATCH: begin
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            if (status.out_free) begin
               state_in = req_valid ? ST_MATCH : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs: a new beat is taken in the same cycle the previous one commits
   always_comb begin
      req_ready       = 1'b0;
      cmd.load_frame  = 1'b0;
      cmd.latch_match = 1'b0;
      cmd.commit      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready      = 1'b1;
            cmd.load_frame = req_valid;
         end
         ST_MATCH: begin
            cmd.latch_match = 1'b1;
         end
         ST_WRITE: begin
            cmd.commit     = status.out_free;
            req_ready      = status.out_free;
            cmd.load_frame = status.out_free & req_valid;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

/* rtl/cfmt_datapath.sv */
module cfmt_datapath
   import cfmt_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [STD_ID_W-1:0]  csr_wdata,
   input  logic [STD_ID_W-1:0]  req_std_id,
   input  logic [EXT_ID_W-1:0]  req_ext_id,
   input  logic                 req_id_type,
   input  logic                 req_remote,
   input  logic [LENGTH_W-1:0]  req_length,
   input  logic [PAYLOAD_W-1:0] req_payload,
   input  logic [TIME_W-1:0]    req_now_ms,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [SLOT_W-1:0]    rsp_slot,
   output logic                 rsp_new_entry,
   output logic                 rsp_overwrote,
   output logic [COUNT_W-1:0]   rsp_frame_count,
   input  cmd_type              cmd,
   output status_type           status
);

   // Configuration register
   logic [STD_ID_W-1:0] match_id_ff;

   // Captured frame
   logic [STD_ID_W-1:0]  std_id_ff;
   logic [EXT_ID_W-1:0]  ext_id_ff;
   logic                 id_type_ff;
   logic                 remote_ff;
   logic [LENGTH_W-1:0]  length_ff;
   logic [PAYLOAD_W-1:0] payload_ff;
   logic [TIME_W-1:0]    now_ms_ff;

   // Table; entries below used_ff are valid since slots fill in order
   logic [STD_ID_W-1:0]  ent_std_ff     [TABLE_ENTRIES];
   logic [EXT_ID_W-1:0]  ent_ext_ff     [TABLE_ENTRIES];
   logic                 ent_type_ff    [TABLE_ENTRIES];
   logic                 ent_remote_ff  [TABLE_ENTRIES];
   logic [LENGTH_W-1:0]  ent_length_ff  [TABLE_ENTRIES];
   logic [PAYLOAD_W-1:0] ent_payload_ff [TABLE_ENTRIES];
   logic [TIME_W-1:0]    ent_time_ff    [TABLE_ENTRIES];
   logic [COUNT_W-1:0]   ent_count_ff   [TABLE_ENTRIES];
   logic [USED_W-1:0]    used_ff;

   // Match result
   logic [IDX_W-1:0] slot_ff;
   logic             found_ff;
   logic             over_ff;

   // Result register
   logic               rsp_valid_ff;
   logic [SLOT_W-1:0]  rsp_slot_ff;
   logic               rsp_new_ff;
   logic               rsp_over_ff;
   logic [COUNT_W-1:0] rsp_count_ff;

   logic [TABLE_ENTRIES-1:0] hit;
   logic [PAYLOAD_W-1:0]     mask;
   logic                     check_data;
   logic [IDX_W-1:0]         slot_in;
   logic                     found_in;
   logic                     over_in;
   logic [COUNT_W-1:0]       count_in;

   // Write the match id register
   always_ff @(posedge clock) begin
      if (reset) begin
         match_id_ff <= DATA_MATCH_ID_RST;
      end else if (csr_we) begin
         match_id_ff <= csr_wdata;
      end
   end

   // Capture the accepted frame
   always_ff @(posedge clock) begin
      if (cmd.load_frame) begin
         std_id_ff  <= req_std_id;
         ext_id_ff  <= req_ext_id;
         id_type_ff <= req_id_type;
         remote_ff  <= req_remote;
         length_ff  <= req_length;
         payload_ff <= req_payload;
         now_ms_ff  <= req_now_ms;
      end
   end

   // Compare the frame against every valid entry in parallel
   assign mask       = byte_mask(length_ff);
   assign check_data = (std_id_ff == match_id_ff);

   always_comb begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         hit[i] = (USED_W'(i) < used_ff)
                  && (ent_std_ff[i] == std_id_ff)
                  && (ent_ext_ff[i] == ext_id_ff)
                  && (ent_type_ff[i] == id_type_ff)
                  && (ent_length_ff[i] == length_ff)
                  && (!check_data || (((ent_payload_ff[i] ^ payload_ff) & mask) == '0));
      end
   end

   // Pick the lowest hit, else the next free slot, else the last slot
   always_comb begin
      found_in = |hit;
      over_in  = 1'b0;
      slot_in  = '0;
      if (found_in) begin
         for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
            if (hit[i]) begin
               slot_in = IDX_W'(i);
            end
         end
      end else if (used_ff < USED_W'(TABLE_ENTRIES)) begin
         slot_in = used_ff[IDX_W-1:0];
      end else begin
         slot_in = IDX_W'(TABLE_ENTRIES - 1);
         over_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_match) begin
         slot_ff  <= slot_in;
         found_ff <= found_in;
         over_ff  <= over_in;
      end
   end

   // A slot taken fresh has never counted a frame
   assign count_in = (found_ff || over_ff) ? ent_count_ff[slot_ff] + COUNT_W'(1)
                                           : COUNT_W'(1);

   // Write back the chosen entry
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         ent_std_ff[slot_ff]     <= std_id_ff;
         ent_ext_ff[slot_ff]     <= ext_id_ff;
         ent_type_ff[slot_ff]    <= id_type_ff;
         ent_remote_ff[slot_ff]  <= remote_ff;
         ent_length_ff[slot_ff]  <= length_ff;
         ent_payload_ff[slot_ff] <= payload_ff;
         ent_time_ff[slot_ff]    <= now_ms_ff;
         ent_count_ff[slot_ff]   <= count_in;
      end
   end

   // Advance the fill count on a fresh slot
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else if (cmd.commit && !found_ff && !over_ff) begin
         used_ff <= used_ff + USED_W'(1);
      end
   end

   // Result register: load on commit, drop when the beat is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_slot_ff  <= SLOT_W'(slot_ff);
         rsp_new_ff   <= !found_ff;
         rsp_over_ff  <= over_ff;
         rsp_count_ff <= count_in;
      end
   end

   assign status.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_slot        = rsp_slot_ff;
   assign rsp_new_entry   = rsp_new_ff;
   assign rsp_overwrote   = rsp_over_ff;
   assign rsp_frame_count = rsp_count_ff;

endmodule

/* rtl/can_frame_monitor_table.sv */
// An accepted request beat is captured, matched against the table in ST_MATCH
// and written back in ST_WRITE, which loads the result register; a new beat
//    is taken only in ST_IDLE or as the previous one commits.
// A stalled response holds the write-back until the result register frees.
// Reset (synchronous, active high) empties the table and loads match id 1023.
module can_frame_monitor_table
   import cfmt_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [STD_ID_W-1:0]  csr_wdata,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [STD_ID_W-1:0]  req_std_id,
   input  logic [EXT_ID_W-1:0]  req_ext_id,
   input  logic                 req_id_type,
   input  logic                 req_remote,
   input  logic [LENGTH_W-1:0]  req_length,
   input  logic [PAYLOAD_W-1:0] req_payload,
   input  logic [TIME_W-1:0]    req_now_ms,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [SLOT_W-1:0]    rsp_slot,
   output logic                 rsp_new_entry,
   output logic                 rsp_overwrote,
   output logic [COUNT_W-1:0]   rsp_frame_count
);

   cmd_type    cmd;
   status_type status;

   cfmt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   cfmt_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .req_std_id      (req_std_id),
      .req_ext_id      (req_ext_id),
      .req_id_type     (req_id_type),
      .req_remote      (req_remote),
      .req_length      (req_length),
      .req_payload     (req_payload),
      .req_now_ms      (req_now_ms),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_slot        (rsp_slot),
      .rsp_new_entry   (rsp_new_entry),
      .rsp_overwrote   (rsp_overwrote),
      .rsp_frame_count (rsp_frame_count),
      .cmd             (cmd),
      .status          (status)
   );

endmodule

/* tb/sv/tb_can_frame_monitor_table.sv */
module tb_can_frame_monitor_table
   import cfmt_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int POOL_SIZE      = 24;
   localparam int SETTLE_CYCLES  = 8;

   typedef struct {
      logic [STD_ID_W-1:0]  std_id;
      logic [EXT_ID_W-1:0]  ext_id;
      logic                 id_type;
      logic                 remote;
      logic [LENGTH_W-1:0]  length;
      logic [PAYLOAD_W-1:0] payload;
      logic [TIME_W-1:0]    now_ms;
   } can_frame_type;

   typedef struct {
      logic [SLOT_W-1:0]  slot;
      logic               new_entry;
      logic               overwrote;
      logic [COUNT_W-1:0] frame_count;
   } slot_update_type;

   logic                 clock;
   logic                 reset           = 1'b1;
   logic                 csr_we          = 1'b0;
   logic [STD_ID_W-1:0]  csr_wdata       = '0;
   logic                 req_valid       = 1'b0;
   logic                 req_ready;
   logic [STD_ID_W-1:0]  req_std_id      = '0;
   logic [EXT_ID_W-1:0]  req_ext_id      = '0;
   logic                 req_id_type     = 1'b0;
   logic                 req_remote      = 1'b0;
   logic [LENGTH_W-1:0]  req_length      = '0;
   logic [PAYLOAD_W-1:0] req_payload     = '0;
   logic [TIME_W-1:0]    req_now_ms      = '0;
   logic                 rsp_valid;
   logic                 rsp_ready       = 1'b0;
   logic [SLOT_W-1:0]    rsp_slot;
   logic                 rsp_new_entry;
   logic                 rsp_overwrote;
   logic [COUNT_W-1:0]   rsp_frame_count;

   // Table shadow kept in step with every accepted request beat
   logic                 shadow_valid [TABLE_ENTRIES];
   can_frame_type        shadow_frame [TABLE_ENTRIES];
   logic [COUNT_W-1:0]   shadow_count [TABLE_ENTRIES];
   int                   shadow_used;
   logic [STD_ID_W-1:0]  shadow_match_id;

   can_frame_type        pending_frames [$];
   can_frame_type        frame_pool [$];
   can_frame_type        frame_on_bus;
   slot_update_type      expected_updates [$];

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int error_count    = 0;
   int stall_cycles   = 0;
   int frames_seen    = 0;
   int frames_matched = 0;
   int frames_added   = 0;
   int frames_replaced = 0;

   can_frame_monitor_table u_dut (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_std_id      (req_std_id),
      .req_ext_id      (req_ext_id),
      .req_id_type     (req_id_type),
      .req_remote      (req_remote),
      .req_length      (req_length),
      .req_payload     (req_payload),
      .req_now_ms      (req_now_ms),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_slot        (rsp_slot),
      .rsp_new_entry   (rsp_new_entry),
      .rsp_overwrote   (rsp_overwrote),
      .rsp_frame_count (rsp_frame_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Search the shadow table, then rewrite the chosen slot and bump its count
   function automatic slot_update_type record_frame(input can_frame_type f);
      int                   hit;
      int                   slot;
      logic [PAYLOAD_W-1:0] mask;
      logic                 check_payload;
      slot_update_type      upd;
      hit = -1;
      check_payload = (f.std_id == shadow_match_id);
      if (f.length >= 8) begin
         mask = '1;
      end else begin
         mask = (64'd1 << (8 * f.length)) - 64'd1;
      end
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         if (hit < 0 && shadow_valid[i] &&
             shadow_frame[i].std_id == f.std_id &&
             shadow_frame[i].ext_id == f.ext_id &&
             shadow_frame[i].id_type == f.id_type &&
             shadow_frame[i].length == f.length &&
             (!check_payload || ((shadow_frame[i].payload ^ f.payload) & mask) == '0)) begin
            hit = i;
         end
      end
      upd.new_entry = (hit < 0);
      upd.overwrote = 1'b0;
      if (hit >= 0) begin
         slot = hit;
         frames_matched++;
      end else if (shadow_used < TABLE_ENTRIES) begin
         slot = shadow_used;
         shadow_used++;
         frames_added++;
      end else begin
         slot = TABLE_ENTRIES - 1;
         upd.overwrote = 1'b1;
         frames_replaced++;
      end
      shadow_valid[slot] = 1'b1;
      shadow_frame[slot] = f;
      shadow_count[slot] = shadow_count[slot] + 1'b1;
      upd.slot = SLOT_W'(slot);
      upd.frame_count = shadow_count[slot];
      frames_seen++;
      return upd;
   endfunction

   function automatic can_frame_type make_frame(input int std_id, input int ext_id,
                                                input bit id_type, input bit remote,
                                                input int length, input logic [63:0] payload,
                                                input int now_ms);
      can_frame_type f;
      f.std_id  = STD_ID_W'(std_id);
      f.ext_id  = EXT_ID_W'(ext_id);
      f.id_type = id_type;
      f.remote  = remote;
      f.length  = LENGTH_W'(length);
      f.payload = payload;
      f.now_ms  = TIME_W'(now_ms);
      return f;
   endfunction

   function automatic can_frame_type random_frame();
      can_frame_type f;
      f.std_id  = STD_ID_W'($urandom_range(0, 2047));
      f.ext_id  = EXT_ID_W'($urandom());
      f.id_type = 1'($urandom_range(0, 1));
      f.remote  = 1'($urandom_range(0, 1));
      f.length  = ($urandom_range(0, 9) == 0) ? LENGTH_W'($urandom_range(9, 15))
                                              : LENGTH_W'($urandom_range(0, 8));
      f.payload = {$urandom(), $urandom()};
      f.now_ms  = $urandom();
      return f;
   endfunction

   // Keep the pool bounded: replace a random member once it is full
   task automatic add_to_pool(input can_frame_type f);
      if (frame_pool.size() < POOL_SIZE) begin
         frame_pool.push_back(f);
      end else begin
         frame_pool[$urandom_range(0, POOL_SIZE - 1)] = f;
      end
   endtask

   task automatic queue_frame(input can_frame_type f);
      pending_frames.push_back(f);
      add_to_pool(f);
   endtask

   // Hold until every queued frame went out and every update came back
   task automatic drain();
      do @(negedge clock);
      while (pending_frames.size() != 0 || req_valid || expected_updates.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Mostly repeats and near-repeats of known frames, the rest fresh frames
   task automatic run_phase(input logic [STD_ID_W-1:0] match_id, input int idle_pct,
                            input int stall_pct, input int n_items);
      can_frame_type f;
      int            pick;
      int            b;
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= match_id;
      shadow_match_id = match_id;
      @(posedge clock);
      csr_we <= 1'b0;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      for (int k = 0; k < 4; k++) begin
         f = random_frame();
         f.std_id = match_id;
         add_to_pool(f);
      end
      for (int n = 0; n < n_items; n++) begin
         pick = $urandom_range(0, 99);
         f = frame_pool[$urandom_range(0, frame_pool.size() - 1)];
         if (pick < 55) begin
            f.remote = 1'($urandom_range(0, 1));
         end else if (pick < 70) begin
            b = $urandom_range(0, PAYLOAD_BYTES - 1);
            f.payload[8*b +: 8] = f.payload[8*b +: 8] ^ 8'($urandom_range(1, 255));
         end else if (pick < 80) begin
            case ($urandom_range(0, 3))
               0: f.ext_id[$urandom_range(0, EXT_ID_W - 1)] ^= 1'b1;
               1: f.id_type = ~f.id_type;
               2: f.length = LENGTH_W'($urandom_range(0, 15));
               default: f.std_id[$urandom_range(0, STD_ID_W - 1)] ^= 1'b1;
            endcase
         end else begin
            f = random_frame();
            if ($urandom_range(0, 1) == 1) begin
               add_to_pool(f);
            end
         end
         f.now_ms = $urandom();
         pending_frames.push_back(f);
      end
      drain();
   endtask

   // Drive request beats from the pending queue, predicting each on acceptance
   always @(posedge clock) begin : frame_driver
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_updates.push_back(record_frame(frame_on_bus));
         end
         if (!req_valid || req_ready) begin
            if (pending_frames.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               frame_on_bus = pending_frames.pop_front();
               req_valid   <= 1'b1;
               req_std_id  <= frame_on_bus.std_id;
               req_ext_id  <= frame_on_bus.ext_id;
               req_id_type <= frame_on_bus.id_type;
               req_remote  <= frame_on_bus.remote;
               req_length  <= frame_on_bus.length;
               req_payload <= frame_on_bus.payload;
               req_now_ms  <= frame_on_bus.now_ms;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Check each response beat against the oldest expected update
   always @(posedge clock) begin : update_monitor
      slot_update_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_updates.size() == 0) begin
               $error("response beat with no frame outstanding: slot %0d", rsp_slot);
               error_count++;
            end else begin
               want = expected_updates.pop_front();
               if (rsp_slot !== want.slot) begin
                  $error("slot: expected %0d, got %0d", want.slot, rsp_slot);
                  error_count++;
               end
               if (rsp_new_entry !== want.new_entry) begin
                  $error("new_entry: expected %0b, got %0b", want.new_entry, rsp_new_entry);
                  error_count++;
               end
               if (rsp_overwrote !== want.overwrote) begin
                  $error("overwrote: expected %0b, got %0b", want.overwrote, rsp_overwrote);
                  error_count++;
               end
               if (rsp_frame_count !== want.frame_count) begin
                  $error("frame_count: expected %0d, got %0d", want.frame_count,
                         rsp_frame_count);
                  error_count++;
               end
            end
         end
         rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // Abort when work is outstanding but no beat moves for too long
   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (pending_frames.size() == 0 && !req_valid && expected_updates.size() == 0)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
         $display("tb_can_frame_monitor_table: errors");
         $finish;
      end
   end

   initial begin : sequencer
      logic [PAYLOAD_W-1:0] pat;
      can_frame_type        f;
      pat = 64'h0123_4567_89AB_CDEF;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         shadow_valid[i] = 1'b0;
         shadow_count[i] = '0;
      end
      shadow_used     = 0;
      shadow_match_id = DATA_MATCH_ID_RST;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed frames under the reset match id, filling the table
      queue_frame(make_frame(0, 0, 0, 0, 0, '0, 0));
      queue_frame(make_frame(0, 0, 0, 0, 0, '0, 1));
      queue_frame(make_frame(2047, 29'h1FFF_FFFF, 1, 1, 8, '1, -1));
      // payload compared only over the first length bytes
      queue_frame(make_frame(1023, 5, 0, 0, 2, pat, 10));
      queue_frame(make_frame(1023, 5, 0, 0, 2, pat ^ 64'hFF00_0000, 11));
      queue_frame(make_frame(1023, 5, 0, 0, 2, pat ^ 64'h0100, 12));
      // length above eight compares all eight bytes
      queue_frame(make_frame(1023, 5, 0, 0, 12, pat, 20));
      queue_frame(make_frame(1023, 5, 0, 0, 12, pat ^ 64'h8000_0000_0000_0000, 21));
      // extended frame still keyed on std_id for the payload check
      queue_frame(make_frame(1023, 29'h1ABC_DEF, 1, 0, 8, pat, 30));
      queue_frame(make_frame(1023, 29'h1ABC_DEF, 1, 0, 8, pat ^ 64'h0100_0000_0000_0000, 31));
      // remote flag and payload ignored off the match id
      queue_frame(make_frame(100, 7, 0, 0, 4, pat, 40));
      queue_frame(make_frame(100, 7, 0, 1, 4, ~pat, 41));
      queue_frame(make_frame(100, 8, 0, 0, 4, pat, 42));
      queue_frame(make_frame(100, 7, 1, 0, 4, pat, 43));
      queue_frame(make_frame(100, 7, 0, 0, 5, pat, 44));
      for (int k = 0; k < 4; k++) begin
         f = random_frame();
         f.std_id = STD_ID_W'(200 + k);
         queue_frame(f);
      end
      // table full: replace the last slot, then hit it again
      f = make_frame(300, 12345, 1, 0, 3, pat, 50);
      queue_frame(f);
      f.now_ms = 51;
      queue_frame(f);
      queue_frame(make_frame(0, 0, 0, 0, 0, '0, 52));
      drain();

      run_phase(11'd0,    0,  0, 175);
      run_phase(11'd2047, 51, 0, 175);
      run_phase(STD_ID_W'($urandom_range(0, 2047)), 0, 51, 175);
      run_phase(11'd1023, 26, 26, 175);
      run_phase(STD_ID_W'($urandom_range(0, 2047)), 51, 51, 175);
      run_phase(11'd0,    0,  0, 175);

      $display("covered %0d frames: %0d matched, %0d filled a free slot, %0d replaced the last",
               frames_seen, frames_matched, frames_added, frames_replaced);
      $display("match id swept over reset, 0, 2047 and random values under idle and stall");
      if (error_count == 0) begin
         $display("tb_can_frame_monitor_table: clean");
      end else begin
         $display("tb_can_frame_monitor_table: errors");
      end
      $finish;
   end

endmodule

/* can_frame_monitor_table.f */
rtl/cfmt_pkg.sv
rtl/cfmt_ctrl.sv
rtl/cfmt_datapath.sv
rtl/can_frame_monitor_table.sv
tb/sv/tb_can_frame_monitor_table.sv
